FILE: src/hsa_pkg.sv
// Handle slot allocator: shared package.
// Holds field widths, command/status/state codes, control structs and the xorshift step.
// No dependencies.
`timescale 1ns / 1ps

package hsa_pkg;

  localparam int unsigned SlotW    = 5;
  localparam int unsigned Slots    = 32;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned HndW     = 32;
  localparam int unsigned FsW      = 2;
  localparam int unsigned DescW    = 15;
  localparam int unsigned MaskW    = 4;
  localparam int unsigned FsFieldW = 4;
  localparam int unsigned DescBktW = 6;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_LOOKUP  = 2'd1,
    CMD_RELEASE = 2'd2
  } hsa_cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } hsa_status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SEED,
    S_START,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_DEC_CHK,
    S_DONE
  } hsa_state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic seed;
    logic start;
    logic probe_adv;
    logic alloc_wr;
    logic dec_hit;
    logic set_full;
    logic set_invalid;
    logic out_load;
  } hsa_ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic alloc_ok;
    logic dec_ok;
    logic slot_empty;
    logic probe_last;
    logic clr_last;
    logic out_free;
  } hsa_stat_t;

  function automatic logic [HndW-1:0] xs_next(input logic [HndW-1:0] s);
    logic [HndW-1:0] x;
    x = s ^ (s << 13);
    x = x ^ (x >> 7);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

FILE: src/hsa_ctrl.sv
// Handle slot allocator: sequencing state machine.
// Drives hsa_ctrl_t commands into the datapath from hsa_stat_t status; uses hsa_pkg.
`timescale 1ns / 1ps

module hsa_ctrl
  import hsa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  input  hsa_stat_t stat_i,
  output hsa_ctrl_t ctrl_o
);

  hsa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    ctrl_o    = '0;
    s_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ctrl_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.alloc_ok) begin
          state_d = S_SEED;
        end else if (stat_i.dec_ok) begin
          state_d = S_DEC_CHK;
        end else begin
          ctrl_o.set_invalid = 1'b1;
          state_d            = S_DONE;
        end
      end
      S_SEED: begin
        ctrl_o.seed = 1'b1;
        state_d     = S_START;
      end
      S_START: begin
        ctrl_o.start = 1'b1;
        state_d      = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        state_d = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (stat_i.slot_empty) begin
          ctrl_o.alloc_wr = 1'b1;
          state_d         = S_DONE;
        end else if (stat_i.probe_last) begin
          ctrl_o.set_full = 1'b1;
          state_d         = S_DONE;
        end else begin
          ctrl_o.probe_adv = 1'b1;
          state_d          = S_PROBE_RD;
        end
      end
      S_DEC_CHK: begin
        if (stat_i.slot_empty) begin
          ctrl_o.set_invalid = 1'b1;
        end else begin
          ctrl_o.dec_hit = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/hsa_dp.sv
// Handle slot allocator: datapath with slot memory, counters, probe pointers and result register.
// Executes hsa_ctrl_t commands and reports hsa_stat_t; uses hsa_pkg.
`timescale 1ns / 1ps

module hsa_dp
  import hsa_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS     = 32,
  parameter int unsigned NUM_FILESYSTEMS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MaskW-1:0]    cfg_wdata_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic [CmdW-1:0]     s_tuser_i,
  input  hsa_ctrl_t           ctrl_i,
  output hsa_stat_t           stat_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [OutDataW-1:0] m_tdata_o,
  output logic [StatusW-1:0]  m_tuser_o
);

  localparam int unsigned Depth = MAX_BUCKETS * Slots;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned BktW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned OccW  = $clog2(Depth + 1);
  localparam int unsigned ProdW = HndW + CntW;

  localparam logic [CntW-1:0]     MaxCnt  = CntW'(MAX_BUCKETS);
  localparam logic [FsFieldW-1:0] NumFs   = FsFieldW'(NUM_FILESYSTEMS);
  localparam logic [FsFieldW-1:0] MaskLim = FsFieldW'(MaskW);
  localparam logic [AddrW-1:0]    LastClr = AddrW'(Depth - 1);
  localparam logic [SlotW-1:0]    LastPos = SlotW'(Slots - 1);

  // captured item
  logic [CmdW-1:0]  cmd_q;
  logic [HndW-1:0]  hnd_q;
  logic [FsW-1:0]   fs_q;
  logic [DescW-1:0] desc_q;

  logic [MaskW-1:0] mask_q;
  logic [CntW-1:0]  biu_q;
  logic [OccW-1:0]  occ_q;
  logic [HndW-1:0]  rnd_q;
  logic [BktW-1:0]  bkt_q;
  logic [SlotW-1:0] pos_q;
  logic [SlotW-1:0] pcnt_q;
  logic [CntW-1:0]  bcnt_q;
  logic [AddrW-1:0] clr_q;

  logic [StatusW-1:0] res_status_q;
  logic [DescW-1:0]   res_desc_q;
  logic [HndW-1:0]    res_hnd_q;

  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [DescW-1:0]   out_desc_q;
  logic [HndW-1:0]    out_hnd_q;

  logic [HndW-1:0] slot_mem_q [Depth];
  logic [HndW-1:0] rdata_q;

  logic [AddrW-1:0] addr;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [HndW-1:0]  mem_wdata;

  logic [FsFieldW-1:0] dfs_field, dfs_idx;
  logic                is_release;
  logic                grow;
  logic [OccW:0]       occ_sum;
  logic [ProdW-1:0]    prod;
  logic [HndW-1:0]     rnd2;
  logic [CntW-1:0]     bkt_inc;
  logic [BktW-1:0]     bkt_wrap;

  assign addr       = AddrW'({bkt_q, pos_q});
  assign is_release = (cmd_q == CMD_RELEASE);

  // descriptor checks, all but the occupied test
  assign dfs_field = desc_q[DescW-1 -: FsFieldW];
  assign dfs_idx   = dfs_field - FsFieldW'(1);

  assign stat_o.alloc_ok = (cmd_q == CMD_ALLOC) && (hnd_q != '0)
                         && (FsFieldW'(fs_q) < NumFs);
  assign stat_o.dec_ok   = ((cmd_q == CMD_LOOKUP) || is_release)
                         && (dfs_field != '0) && (dfs_idx < NumFs)
                         && (dfs_idx < MaskLim)
                         && mask_q[dfs_idx[FsW-1:0]]
                         && (desc_q[SlotW +: DescBktW] < biu_q);
  assign stat_o.slot_empty = (rdata_q == '0);
  assign stat_o.probe_last = (pcnt_q == LastPos) && (bcnt_q == biu_q - CntW'(1));
  assign stat_o.clr_last   = (clr_q == LastClr);
  assign stat_o.out_free   = !out_valid_q || m_tready_i;

  // growth when occupancy exceeds 80% of the slots in the buckets in use
  assign occ_sum = (OccW + 1)'(occ_q) + (OccW + 1)'(occ_q >> 2);
  assign grow    = (biu_q < MaxCnt) && (occ_sum > {biu_q, {SlotW{1'b0}}});

  assign prod     = ProdW'(rnd_q) * ProdW'(biu_q);
  assign rnd2     = xs_next(rnd_q);
  assign bkt_inc  = CntW'(bkt_q) + CntW'(1);
  assign bkt_wrap = (bkt_inc == biu_q) ? '0 : BktW'(bkt_inc);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = '0;
    if (ctrl_i.clr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
    end else if (ctrl_i.alloc_wr) begin
      mem_we    = 1'b1;
      mem_wdata = hnd_q;
    end else if (ctrl_i.dec_hit && is_release) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= slot_mem_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      biu_q       <= CntW'(1);
      occ_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (ctrl_i.clr_wr) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (ctrl_i.seed && grow) begin
        biu_q <= biu_q + CntW'(1);
      end
      if (ctrl_i.alloc_wr) begin
        occ_q <= occ_q + OccW'(1);
      end else if (ctrl_i.dec_hit && is_release) begin
        occ_q <= occ_q - OccW'(1);
      end
      if (ctrl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q  <= s_tuser_i;
      hnd_q  <= s_tdata_i[HndW-1:0];
      fs_q   <= s_tdata_i[HndW +: FsW];
      desc_q <= s_tdata_i[HndW + FsW +: DescW];
      bkt_q  <= BktW'(s_tdata_i[HndW + FsW + SlotW +: DescBktW]);
      pos_q  <= s_tdata_i[HndW + FsW +: SlotW];
    end
    if (ctrl_i.seed) begin
      rnd_q <= xs_next(hnd_q ^ HndW'(fs_q));
    end
    if (ctrl_i.start) begin
      pcnt_q <= '0;
      bcnt_q <= '0;
      if (biu_q > CntW'(1)) begin
        bkt_q <= prod[HndW +: BktW];
        pos_q <= rnd2[SlotW-1:0];
      end else begin
        bkt_q <= '0;
        pos_q <= rnd_q[SlotW-1:0];
      end
    end
    if (ctrl_i.probe_adv) begin
      pos_q  <= pos_q + SlotW'(1);
      pcnt_q <= pcnt_q + SlotW'(1);
      if (pcnt_q == LastPos) begin
        bkt_q  <= bkt_wrap;
        bcnt_q <= bcnt_q + CntW'(1);
      end
    end
    if (ctrl_i.set_invalid) begin
      res_status_q <= ST_INVALID;
      res_desc_q   <= '0;
      res_hnd_q    <= '0;
    end else if (ctrl_i.set_full) begin
      res_status_q <= ST_FULL;
      res_desc_q   <= '0;
      res_hnd_q    <= '0;
    end else if (ctrl_i.alloc_wr) begin
      res_status_q <= ST_OK;
      res_desc_q   <= {FsFieldW'(fs_q) + FsFieldW'(1), DescBktW'(bkt_q), pos_q};
      res_hnd_q    <= '0;
    end else if (ctrl_i.dec_hit) begin
      res_status_q <= ST_OK;
      res_desc_q   <= '0;
      res_hnd_q    <= rdata_q;
    end
    if (ctrl_i.out_load) begin
      out_status_q <= res_status_q;
      out_desc_q   <= res_desc_q;
      out_hnd_q    <= res_hnd_q;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_status_q;
  assign m_tdata_o  = {1'b0, out_hnd_q, out_desc_q};

`ifndef SYNTHESIS
  a_biu_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (biu_q >= CntW'(1)) && (biu_q <= MaxCnt))
    else $error("bucket count out of range");

  a_occ_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= {biu_q, {SlotW{1'b0}}})
    else $error("occupancy exceeds enabled capacity");

  a_biu_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    biu_q >= $past(biu_q))
    else $error("bucket count shrank");

  a_alloc_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.alloc_wr |-> (rdata_q == '0) && (bcnt_q < biu_q))
    else $error("allocation overwrote a live slot");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |-> (!out_valid_q || m_tready_i))
    else $error("result register overrun");
`endif

endmodule

FILE: src/handle_slot_allocator_unit.sv
// Handle slot allocator: MAX_BUCKETS x 32 slot table, xorshift-seeded linear probing.
// Lookup/release: decode, slot check, then the result waits for the output register.
// Allocate: decode, seed, start, then a probe read and a probe check per slot probed.
// Invalid items go from decode to the result. Results sit in an output register; a new
// item is taken only in idle. Reset (async, active low): the controller sweeps the slot
// memory to zero, one entry a cycle, with s_axis_tready_o low; config writes still taken.
`timescale 1ns / 1ps

module handle_slot_allocator_unit
  import hsa_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS     = 32,
  parameter int unsigned NUM_FILESYSTEMS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MaskW-1:0]    cfg_wdata_i,      // fs_present_mask
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // handle_value, fs_number, descriptor_in
  input  logic [CmdW-1:0]     s_axis_tuser_i,   // command
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // descriptor_out, handle_out
  output logic [StatusW-1:0]  m_axis_tuser_o    // status
);

  hsa_ctrl_t ctrl;
  hsa_stat_t stat;

  hsa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  hsa_dp #(
    .MAX_BUCKETS     (MAX_BUCKETS),
    .NUM_FILESYSTEMS (NUM_FILESYSTEMS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o)
  );

endmodule
